@@ src/cda_pkg.sv @@
// Shared types, constants and calendar helper functions for the calendar date block.
// No dependencies.
package cda_pkg;

  localparam int YW     = 14;  // year
  localparam int MW     = 4;   // month
  localparam int DW     = 5;   // day of month
  localparam int CNT_IN = 16;  // day count field
  localparam int LO_W   = 7;   // year mod 100
  localparam int QW     = 8;   // year div 100 from the reciprocal product
  localparam int DIST_W = 22;

  // year / 100 == (year * 5243) >> 19, exact for any 14-bit year
  localparam int MUL_W  = 13;
  localparam logic [MUL_W-1:0] DIV100_MUL = 13'd5243;
  localparam int PROD_W = YW + MUL_W;

  localparam logic [DIST_W-1:0] DIST_MAX = 22'h3FFFFF;

  localparam logic [YW-1:0] RST_YEAR  = 14'd0;
  localparam logic [MW-1:0] RST_MONTH = 4'd3;
  localparam logic [DW-1:0] RST_DAY   = 5'd23;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_SUB  = 2'd2;
  localparam logic [1:0] MODE_CMP  = 2'd3;

  localparam logic [1:0] ORD_EQ      = 2'd0;
  localparam logic [1:0] ORD_EARLIER = 2'd1;
  localparam logic [1:0] ORD_LATER   = 2'd2;

  typedef struct packed {
    logic start;
    logic load_chk;
    logic add_step;
    logic sub_step;
    logic dn1;
    logic dn_sel;
    logic dn2_a;
    logic dn2_b;
    logic cmp_fin;
    logic out_load;
  } cda_cmd_t;

  typedef struct packed {
    logic add_done;
    logic sub_done;
  } cda_sts_t;

  // Gregorian leap test from year mod 100 and the low bits of year div 100
  function automatic logic leap_f(input logic [LO_W-1:0] lo, input logic [1:0] hi);
    logic r;
    if (lo == '0) begin
      r = (hi == 2'd0);
    end else begin
      r = (lo[1:0] == 2'd0);
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] dim_f(input logic [MW-1:0] m, input logic leap);
    logic [DW-1:0] r;
    unique case (m) inside
      4'd2:                                      r = leap ? DW'(29) : DW'(28);
      4'd4, 4'd6, 4'd9, 4'd11:                   r = DW'(30);
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = DW'(31);
      default:                                   r = '0;
    endcase
    return r;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] cum_f(input logic [MW-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/cda_in_if.sv @@
// Command channel: valid/ready handshake carrying one command word.
// Depends on cda_pkg.
interface cda_in_if import cda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [YW-1:0]     year_in;
  logic [MW-1:0]     month_in;
  logic [DW-1:0]     day_in;
  logic [CNT_IN-1:0] days_count;

  modport source (output valid, mode, year_in, month_in, day_in, days_count, input ready);
  modport sink (input valid, mode, year_in, month_in, day_in, days_count, output ready);
endinterface

@@ src/cda_out_if.sv @@
// Result channel: valid/ready handshake carrying one result word.
// Depends on cda_pkg.
interface cda_out_if import cda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [YW-1:0]     year_out;
  logic [MW-1:0]     month_out;
  logic [DW-1:0]     day_out;
  logic              error_flag;
  logic [1:0]        order;
  logic [DIST_W-1:0] distance;

  modport source (output valid, year_out, month_out, day_out, error_flag, order, distance,
                  input ready);
  modport sink (input valid, year_out, month_out, day_out, error_flag, order, distance,
                output ready);
endinterface

@@ src/cda_ctrl.sv @@
// Sequencer for the calendar date block: handshakes and datapath commands.
// Depends on cda_pkg.
module cda_ctrl import cda_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [1:0] in_mode,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output cda_cmd_t cmd,
  input  cda_sts_t sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LSPLIT = 4'd1;
  localparam logic [3:0] S_LCHK   = 4'd2;
  localparam logic [3:0] S_ADD    = 4'd3;
  localparam logic [3:0] S_SUB    = 4'd4;
  localparam logic [3:0] S_CSPLIT = 4'd5;
  localparam logic [3:0] S_C1A    = 4'd6;
  localparam logic [3:0] S_C2A    = 4'd7;
  localparam logic [3:0] S_C2B    = 4'd8;
  localparam logic [3:0] S_CFIN   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          unique case (in_mode)
            MODE_LOAD: state_nxt = S_LSPLIT;
            MODE_ADD:  state_nxt = S_ADD;
            MODE_SUB:  state_nxt = S_SUB;
            MODE_CMP:  state_nxt = S_CSPLIT;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_LSPLIT: state_nxt = S_LCHK;
      S_LCHK: begin
        cmd.load_chk = 1'b1;
        state_nxt    = S_DONE;
      end
      S_ADD: begin
        cmd.add_step = 1'b1;
        if (sts.add_done) begin
          state_nxt = S_DONE;
        end
      end
      S_SUB: begin
        cmd.sub_step = 1'b1;
        if (sts.sub_done) begin
          state_nxt = S_DONE;
        end
      end
      S_CSPLIT: state_nxt = S_C1A;
      S_C1A: begin
        cmd.dn1   = 1'b1;
        state_nxt = S_C2A;
      end
      S_C2A: begin
        cmd.dn2_a  = 1'b1;
        cmd.dn1    = 1'b1;
        cmd.dn_sel = 1'b1;
        state_nxt  = S_C2B;
      end
      S_C2B: begin
        cmd.dn2_b = 1'b1;
        state_nxt = S_CFIN;
      end
      S_CFIN: begin
        cmd.cmp_fin = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ src/cda_dp.sv @@
// Datapath for the calendar date block: stored date, month walk, date check,
// day-number compare and the result register. Depends on cda_pkg.
module cda_dp import cda_pkg::*; #(
  parameter int YEAR_LIMIT = 9999,
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cda_cmd_t          cmd,
  output cda_sts_t          sts,
  input  logic [1:0]        in_mode,
  input  logic [YW-1:0]     in_year,
  input  logic [MW-1:0]     in_month,
  input  logic [DW-1:0]     in_day,
  input  logic [CNT_IN-1:0] in_count,
  output logic [YW-1:0]     year_out,
  output logic [MW-1:0]     month_out,
  output logic [DW-1:0]     day_out,
  output logic              error_flag,
  output logic [1:0]        order,
  output logic [DIST_W-1:0] distance
);

  localparam int CNT_W = (COUNT_BITS < CNT_IN) ? COUNT_BITS : CNT_IN;
  localparam int WD_W  = CNT_W + 2;
  localparam int HI_W  = $clog2(YEAR_LIMIT / 100 + 2);
  localparam int DN_W  = $clog2(366 * (YEAR_LIMIT + 1));
  localparam int DX_W  = (DN_W > DIST_W) ? DN_W : DIST_W;
  localparam logic [YW-1:0] YLIM = YW'(YEAR_LIMIT);

  // stored date
  logic [YW-1:0]   cur_year_r;
  logic [MW-1:0]   cur_month_r;
  logic [DW-1:0]   cur_day_r;
  logic [LO_W-1:0] cur_lo_r;
  logic [HI_W-1:0] cur_hi_r;

  // latched command operands
  logic [YW-1:0]     yi_r;
  logic [MW-1:0]     mi_r;
  logic [DW-1:0]     di_r;
  logic [PROD_W-1:0] prod_r;

  // month walk
  logic [YW-1:0]   w_y_r;
  logic [MW-1:0]   w_m_r;
  logic [WD_W-1:0] w_d_r;
  logic [LO_W-1:0] w_lo_r;
  logic [HI_W-1:0] w_hi_r;

  // day numbers
  logic [DN_W-1:0] yterm_r, dn_a_r, dn_b_r;
  logic [8:0]      md_r;

  logic              err_r;
  logic [1:0]        ord_r;
  logic [DIST_W-1:0] dist_r;

  logic [CNT_W-1:0] cnt;
  logic [QW-1:0]    q;
  logic [HI_W-1:0]  in_hi;
  logic [LO_W-1:0]  in_lo;
  logic             in_leap, in_ok;
  logic [DW-1:0]    in_dim;

  logic            w_leap;
  logic [DW-1:0]   add_dm, sub_dm;
  logic [MW-1:0]   sub_m;
  logic            add_more, add_ovf, sub_more, sub_unf;
  logic [YW-1:0]   y_inc, y_dec;
  logic [LO_W-1:0] lo_inc, lo_dec;
  logic [HI_W-1:0] hi_inc, hi_dec;

  logic [YW-1:0]   s_y, s_ym1;
  logic [MW-1:0]   s_m;
  logic [DW-1:0]   s_d;
  logic [LO_W-1:0] s_lo;
  logic [HI_W-1:0] s_hi, s_phi;
  logic            s_leap;
  logic [DN_W-1:0] yterm, dn_sum, diff;
  logic [8:0]      md;
  logic [DX_W-1:0] diff_x;

  assign cnt = in_count[CNT_W-1:0];

  // split of the given year into div/mod 100
  assign q       = prod_r[PROD_W-1 -: QW];
  assign in_hi   = HI_W'(q);
  assign in_lo   = LO_W'(yi_r - YW'(q) * YW'(100));
  assign in_leap = leap_f(in_lo, 2'(in_hi));
  assign in_dim  = dim_f(mi_r, in_leap);
  assign in_ok   = (yi_r <= YLIM) && (di_r != '0) && (di_r <= in_dim);

  // walk step
  assign w_leap   = leap_f(w_lo_r, 2'(w_hi_r));
  assign add_dm   = dim_f(w_m_r, w_leap);
  assign add_more = (w_d_r > WD_W'(add_dm));
  assign add_ovf  = add_more && (w_m_r == MW'(12)) && (w_y_r >= YLIM);
  assign sub_m    = (w_m_r == MW'(1)) ? MW'(12) : w_m_r - MW'(1);
  assign sub_dm   = dim_f(sub_m, w_leap);
  assign sub_more = w_d_r[WD_W-1] || (w_d_r == '0);
  assign sub_unf  = sub_more && (w_m_r == MW'(1)) && (w_y_r == '0);

  assign sts.add_done = !add_more || add_ovf;
  assign sts.sub_done = !sub_more || sub_unf;

  assign y_inc  = w_y_r + YW'(1);
  assign lo_inc = (w_lo_r == LO_W'(99)) ? '0 : w_lo_r + LO_W'(1);
  assign hi_inc = (w_lo_r == LO_W'(99)) ? w_hi_r + HI_W'(1) : w_hi_r;
  assign y_dec  = w_y_r - YW'(1);
  assign lo_dec = (w_lo_r == '0) ? LO_W'(99) : w_lo_r - LO_W'(1);
  assign hi_dec = (w_lo_r == '0) ? w_hi_r - HI_W'(1) : w_hi_r;

  // day number, first half: whole years before the date; second half: within the year
  assign s_y    = cmd.dn_sel ? yi_r  : cur_year_r;
  assign s_m    = cmd.dn_sel ? mi_r  : cur_month_r;
  assign s_d    = cmd.dn_sel ? di_r  : cur_day_r;
  assign s_lo   = cmd.dn_sel ? in_lo : cur_lo_r;
  assign s_hi   = cmd.dn_sel ? in_hi : cur_hi_r;
  assign s_leap = leap_f(s_lo, 2'(s_hi));
  assign s_ym1  = s_y - YW'(1);
  assign s_phi  = (s_lo == '0) ? s_hi - HI_W'(1) : s_hi;
  assign yterm  = DN_W'(s_y) * DN_W'(365) +
                  ((s_y != '0) ? (DN_W'(s_ym1 >> 2) - DN_W'(s_phi) + DN_W'(s_phi >> 2) +
                                  DN_W'(1)) : '0);
  assign md     = cum_f(s_m) + 9'(s_leap && (s_m > MW'(2))) + 9'(s_d) - 9'(1);
  assign dn_sum = yterm_r + DN_W'(md_r);

  assign diff   = (dn_a_r < dn_b_r) ? dn_b_r - dn_a_r : dn_a_r - dn_b_r;
  assign diff_x = DX_W'(diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_year_r  <= RST_YEAR;
      cur_month_r <= RST_MONTH;
      cur_day_r   <= RST_DAY;
      cur_lo_r    <= '0;
      cur_hi_r    <= '0;
    end else if (cmd.load_chk && in_ok) begin
      cur_year_r  <= yi_r;
      cur_month_r <= mi_r;
      cur_day_r   <= di_r;
      cur_lo_r    <= in_lo;
      cur_hi_r    <= in_hi;
    end else if ((cmd.add_step && !add_more) || (cmd.sub_step && !sub_more)) begin
      cur_year_r  <= w_y_r;
      cur_month_r <= w_m_r;
      cur_day_r   <= DW'(w_d_r);
      cur_lo_r    <= w_lo_r;
      cur_hi_r    <= w_hi_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(yi_r) * PROD_W'(DIV100_MUL);

    if (cmd.start) begin
      yi_r   <= in_year;
      mi_r   <= in_month;
      di_r   <= in_day;
      err_r  <= 1'b0;
      ord_r  <= ORD_EQ;
      dist_r <= '0;
      w_y_r  <= cur_year_r;
      w_m_r  <= cur_month_r;
      w_lo_r <= cur_lo_r;
      w_hi_r <= cur_hi_r;
      if (in_mode == MODE_SUB) begin
        w_d_r <= WD_W'(cur_day_r) - WD_W'(cnt);
      end else begin
        w_d_r <= WD_W'(cur_day_r) + WD_W'(cnt);
      end
    end

    if (cmd.load_chk && !in_ok) begin
      err_r <= 1'b1;
    end

    if (cmd.add_step && add_more) begin
      if (add_ovf) begin
        err_r <= 1'b1;
      end else begin
        w_d_r <= w_d_r - WD_W'(add_dm);
        if (w_m_r == MW'(12)) begin
          w_m_r  <= MW'(1);
          w_y_r  <= y_inc;
          w_lo_r <= lo_inc;
          w_hi_r <= hi_inc;
        end else begin
          w_m_r <= w_m_r + MW'(1);
        end
      end
    end

    if (cmd.sub_step && sub_more) begin
      if (sub_unf) begin
        err_r <= 1'b1;
      end else begin
        w_d_r <= w_d_r + WD_W'(sub_dm);
        w_m_r <= sub_m;
        if (w_m_r == MW'(1)) begin
          w_y_r  <= y_dec;
          w_lo_r <= lo_dec;
          w_hi_r <= hi_dec;
        end
      end
    end

    if (cmd.dn1) begin
      yterm_r <= yterm;
      md_r    <= md;
    end
    if (cmd.dn2_a) begin
      dn_a_r <= dn_sum;
    end
    if (cmd.dn2_b) begin
      dn_b_r <= dn_sum;
    end

    if (cmd.cmp_fin) begin
      if (!in_ok) begin
        err_r <= 1'b1;
      end else begin
        if (dn_a_r < dn_b_r) begin
          ord_r <= ORD_EARLIER;
        end else if (dn_a_r > dn_b_r) begin
          ord_r <= ORD_LATER;
        end else begin
          ord_r <= ORD_EQ;
        end
        dist_r <= (diff_x > DX_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(diff_x);
      end
    end

    if (cmd.out_load) begin
      year_out   <= cur_year_r;
      month_out  <= cur_month_r;
      day_out    <= cur_day_r;
      error_flag <= err_r;
      order      <= ord_r;
      distance   <= dist_r;
    end
  end

endmodule

@@ src/calendar_date_arithmetic_top.sv @@
// Gregorian date register with day add/subtract, load check and compare/distance.
// Steps, accept to result valid: a load splits the year and checks the date; a compare splits,
// forms both day numbers and compares; add/subtract walk the date one month per cycle.
// One word in flight; the next word is taken once the result is in the output register.
// Reset (synchronous, rst_n low) sets the date to year 0, March 23 with no result pending.
// Depends on cda_pkg, cda_in_if, cda_out_if, cda_ctrl, cda_dp.
module calendar_date_arithmetic_top import cda_pkg::*; #(
  parameter int YEAR_LIMIT = 9999,
  parameter int COUNT_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  cda_in_if.sink    in_ch,
  cda_out_if.source out_ch
);

  cda_cmd_t cmd;
  cda_sts_t sts;
  logic     in_ready_w;
  logic     out_valid_w;

  assign in_ch.ready  = in_ready_w;
  assign out_ch.valid = out_valid_w;

  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ready_w),
    .out_ready (out_ch.ready),
    .out_valid (out_valid_w),
    .cmd       (cmd),
    .sts       (sts)
  );

  cda_dp #(
    .YEAR_LIMIT (YEAR_LIMIT),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_ch.mode),
    .in_year    (in_ch.year_in),
    .in_month   (in_ch.month_in),
    .in_day     (in_ch.day_in),
    .in_count   (in_ch.days_count),
    .year_out   (out_ch.year_out),
    .month_out  (out_ch.month_out),
    .day_out    (out_ch.day_out),
    .error_flag (out_ch.error_flag),
    .order      (out_ch.order),
    .distance   (out_ch.distance)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("word accepted while previous word in progress");

  a_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.month_out >= MW'(1)) && (out_ch.month_out <= MW'(12)) &&
                     (out_ch.day_out != '0) && (out_ch.year_out <= YW'(YEAR_LIMIT)))
    else $error("stored date out of range");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error_flag |-> (out_ch.order == ORD_EQ) && (out_ch.distance == '0))
    else $error("error result carries order or distance");

  a_dist_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.distance == '0) == (out_ch.order == ORD_EQ)))
    else $error("distance and order disagree");

endmodule

@@ verif/calendar_date_arithmetic_top_test.sv @@
// Testbench for calendar_date_arithmetic_top: load, add, subtract and compare of dates,
// checked word by word against a behavioral calendar predictor, with random idling.
// Depends on cda_pkg, cda_in_if, cda_out_if and the block under test.
module calendar_date_arithmetic_top_test;
  import cda_pkg::*;

  localparam int LAST_YEAR   = 9999;
  localparam int COUNT_WIDTH = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_WORDS = 255;

  typedef struct packed {
    logic [YW-1:0]     year;
    logic [MW-1:0]     month;
    logic [DW-1:0]     day;
    logic              err;
    logic [1:0]        ord;
    logic [DIST_W-1:0] days_apart;
  } date_result_t;

  logic clk = 1'b0;
  logic rst_n;

  cda_in_if  in_ch();
  cda_out_if out_ch();

  calendar_date_arithmetic_top #(
    .YEAR_LIMIT(LAST_YEAR),
    .COUNT_BITS(COUNT_WIDTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // predicted calendar state
  logic [YW-1:0] held_year;
  logic [MW-1:0] held_month;
  logic [DW-1:0] held_day;

  date_result_t expected_dates[$];
  int  mismatch_count = 0;
  int  results_checked = 0;
  int  errors_expected = 0;
  int  words_by_mode[4] = '{default: 0};
  int  cycle_count = 0;
  int  rx_wait = 0;
  logic no_idle = 1'b0;
  logic hold_active = 1'b0;

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2:                      return leap ? 29 : 28;
      4, 6, 9, 11:            return 30;
      1, 3, 5, 7, 8, 10, 12:  return 31;
      default:                return 0;
    endcase
  endfunction

  function automatic bit date_ok(int unsigned y, int unsigned m, int unsigned d);
    if (y > LAST_YEAR || m < 1 || m > 12) return 1'b0;
    return d >= 1 && d <= month_length(y, m);
  endfunction

  // days from Jan 1 of year 0; year 0 is leap
  function automatic int unsigned days_since_epoch(int unsigned y, int unsigned m,
                                                   int unsigned d);
    int unsigned n;
    n = 365 * y;
    if (y > 0) n += (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
    for (int unsigned k = 1; k < m; k++) n += month_length(y, k);
    return n + d - 1;
  endfunction

  function automatic date_result_t advance_calendar(logic [1:0] mode, logic [YW-1:0] yi,
                                                    logic [MW-1:0] mi, logic [DW-1:0] di,
                                                    logic [CNT_IN-1:0] cnt);
    date_result_t r;
    int unsigned  y, m, a, b, span, amount;
    int           d;
    bit           fail;
    r      = '0;
    fail   = 1'b0;
    span   = 0;
    y      = held_year;
    m      = held_month;
    amount = int'(cnt) & ((1 << COUNT_WIDTH) - 1);
    case (mode)
      MODE_LOAD: begin
        if (date_ok(yi, mi, di)) begin
          held_year  = yi;
          held_month = mi;
          held_day   = di;
        end else begin
          fail = 1'b1;
        end
      end
      MODE_ADD: begin
        d = held_day + amount;
        while (d > month_length(y, m)) begin
          d -= month_length(y, m);
          m++;
          if (m == 13) begin
            m = 1;
            if (y >= LAST_YEAR) begin
              fail = 1'b1;
              break;
            end
            y++;
          end
        end
        if (!fail) begin
          held_year  = YW'(y);
          held_month = MW'(m);
          held_day   = DW'(d);
        end
      end
      MODE_SUB: begin
        d = int'(held_day) - int'(amount);
        while (d <= 0) begin
          m--;
          if (m == 0) begin
            if (y == 0) begin
              fail = 1'b1;
              break;
            end
            y--;
            m = 12;
          end
          d += month_length(y, m);
        end
        if (!fail) begin
          held_year  = YW'(y);
          held_month = MW'(m);
          held_day   = DW'(d);
        end
      end
      MODE_CMP: begin
        if (date_ok(yi, mi, di)) begin
          a = days_since_epoch(held_year, held_month, held_day);
          b = days_since_epoch(yi, mi, di);
          if (a < b) begin
            r.ord = ORD_EARLIER;
            span  = b - a;
          end else if (a > b) begin
            r.ord = ORD_LATER;
            span  = a - b;
          end else begin
            r.ord = ORD_EQ;
          end
          if (span > DIST_MAX) span = DIST_MAX;
          r.days_apart = DIST_W'(span);
        end else begin
          fail = 1'b1;
        end
      end
    endcase
    r.year  = held_year;
    r.month = held_month;
    r.day   = held_day;
    r.err   = fail;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // one command word; called at a rising edge, returns at the accepting edge
  task automatic send_cmd(input logic [1:0] mode, input int unsigned yr, input int unsigned mo,
                          input int unsigned dy, input int unsigned cnt);
    int           gap;
    date_result_t want;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.year_in    <= YW'(yr);
    in_ch.month_in   <= MW'(mo);
    in_ch.day_in     <= DW'(dy);
    in_ch.days_count <= CNT_IN'(cnt);
    want = advance_calendar(mode, YW'(yr), MW'(mo), DW'(dy), CNT_IN'(cnt));
    expected_dates.push_back(want);
    words_by_mode[mode]++;
    if (want.err) errors_expected++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic void pick_date(output int unsigned y, output int unsigned m,
                                    output int unsigned d);
    case ($urandom_range(0, 4))
      0:       y = $urandom_range(0, LAST_YEAR);
      1:       y = $urandom_range(0, 99) * 100;
      2:       y = $urandom_range(0, 2499) * 4;
      3:       y = $urandom_range(0, 3);
      default: y = $urandom_range(LAST_YEAR - 3, LAST_YEAR);
    endcase
    m = $urandom_range(1, 12);
    d = ($urandom_range(0, 3) == 0) ? month_length(y, m) : $urandom_range(1, month_length(y, m));
  endfunction

  function automatic int unsigned pick_count();
    case ($urandom_range(0, 11))
      0:       return $urandom_range(0, 65535);
      1, 2:    return $urandom_range(0, 31);
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  task automatic test_directed();
    send_cmd(MODE_CMP, 0, 3, 23, 0);          // reset date
    send_cmd(MODE_SUB, 0, 0, 0, 100);         // before year 0
    send_cmd(MODE_ADD, 16383, 15, 31, 0);
    send_cmd(MODE_LOAD, 0, 1, 1, 0);
    send_cmd(MODE_SUB, 0, 0, 0, 1);
    send_cmd(MODE_LOAD, 9999, 12, 31, 65535);
    send_cmd(MODE_ADD, 0, 0, 0, 1);           // past last year
    send_cmd(MODE_CMP, 0, 1, 1, 0);           // widest span
    send_cmd(MODE_LOAD, 16383, 12, 31, 0);
    send_cmd(MODE_LOAD, 2000, 0, 5, 0);
    send_cmd(MODE_LOAD, 2000, 13, 5, 0);
    send_cmd(MODE_LOAD, 2000, 15, 31, 0);
    send_cmd(MODE_LOAD, 2000, 4, 0, 0);
    send_cmd(MODE_LOAD, 2000, 4, 31, 0);
    send_cmd(MODE_LOAD, 1900, 2, 29, 0);      // century, not leap
    send_cmd(MODE_LOAD, 2000, 2, 29, 0);      // divisible by 400
    send_cmd(MODE_ADD, 0, 0, 0, 365);
    send_cmd(MODE_SUB, 0, 0, 0, 65535);
    send_cmd(MODE_ADD, 0, 0, 0, 65535);
    send_cmd(MODE_CMP, 2100, 2, 29, 0);
    send_cmd(MODE_CMP, 2024, 2, 29, 0);
    send_cmd(MODE_LOAD, 1999, 12, 31, 0);
    send_cmd(MODE_ADD, 0, 0, 0, 1);           // year rollover
    send_cmd(MODE_CMP, 2000, 1, 1, 0);
  endtask

  // receiver holds off while the sender keeps offering words back to back
  task automatic test_backpressure();
    no_idle <= 1'b1;
    fork
      begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
      end
    join_none
    for (int i = 0; i < 10; i++) send_cmd(MODE_ADD, 0, 0, 0, $urandom_range(0, 60));
    no_idle <= 1'b0;
  endtask

  task automatic test_random();
    int unsigned y, m, d, kind;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 90) no_idle <= 1'b1;
      if (i == 150) no_idle <= 1'b0;
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        pick_date(y, m, d);
        send_cmd(MODE_LOAD, y, m, d, $urandom);
      end else if (kind < 25) begin
        send_cmd(MODE_LOAD, $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 55) begin
        send_cmd(MODE_ADD, $urandom, $urandom, $urandom, pick_count());
      end else if (kind < 80) begin
        send_cmd(MODE_SUB, $urandom, $urandom, $urandom, pick_count());
      end else if (kind < 95) begin
        pick_date(y, m, d);
        send_cmd(MODE_CMP, y, m, d, $urandom);
      end else begin
        send_cmd(MODE_CMP, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // result side: check each accepted word, then draw the next stall
  always @(posedge clk) begin
    date_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (expected_dates.size() == 0) begin
          report_mismatch("result word with nothing pending, year", out_ch.year_out, 0);
        end else begin
          want = expected_dates.pop_front();
          if (out_ch.year_out !== want.year)
            report_mismatch("year_out", out_ch.year_out, want.year);
          if (out_ch.month_out !== want.month)
            report_mismatch("month_out", out_ch.month_out, want.month);
          if (out_ch.day_out !== want.day)
            report_mismatch("day_out", out_ch.day_out, want.day);
          if (out_ch.error_flag !== want.err)
            report_mismatch("error_flag", out_ch.error_flag, want.err);
          if (out_ch.order !== want.ord)
            report_mismatch("order", out_ch.order, want.ord);
          if (out_ch.distance !== want.days_apart)
            report_mismatch("distance", out_ch.distance, want.days_apart);
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, 7);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ch.ready <= !hold_active && (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles, %0d words pending", $time, cycle_count,
               expected_dates.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_LOAD;
    in_ch.year_in    <= '0;
    in_ch.month_in   <= '0;
    in_ch.day_in     <= '0;
    in_ch.days_count <= '0;
    held_year  = RST_YEAR;
    held_month = RST_MONTH;
    held_day   = RST_DAY;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_random();

    in_ch.valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_dates.size() != 0)
      report_mismatch("words still pending at end", expected_dates.size(), 0);

    $display("Ran %0d loads, %0d adds, %0d subtracts, %0d compares; %0d result words checked",
             words_by_mode[MODE_LOAD], words_by_mode[MODE_ADD], words_by_mode[MODE_SUB],
             words_by_mode[MODE_CMP], results_checked);
    $display("%0d words were expected to flag an error; %0d mismatches",
             errors_expected, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/cda_pkg.sv
src/cda_in_if.sv
src/cda_out_if.sv
src/cda_ctrl.sv
src/cda_dp.sv
src/calendar_date_arithmetic_top.sv
verif/calendar_date_arithmetic_top_test.sv
